/* sv/fqp_pkg.sv */
package fqp_pkg;

   typedef enum logic [1:0] {
      PH_NAME = 2'd0,
      PH_SEQ  = 2'd1,
      PH_PLUS = 2'd2,
      PH_QUAL = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      CTL_IDLE    = 3'd0,
      CTL_MATCH   = 3'd1,
      CTL_MWAIT   = 3'd2,
      CTL_KEEP    = 3'd3,
      CTL_QREAD   = 3'd4,
      CTL_OUT     = 3'd5
   } ctl_type;

   localparam logic [1:0] KIND_NAME   = 2'd0;
   localparam logic [1:0] KIND_PAIR   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_AT    = 3'd1;
   localparam logic [2:0] ST_PLUS     = 3'd2;
   localparam logic [2:0] ST_LENGTH   = 3'd3;
   localparam logic [2:0] ST_CUT      = 3'd4;
   localparam logic [2:0] ST_OVERLONG = 3'd5;
   localparam logic [2:0] ST_NONE     = 3'd6;

   localparam logic [7:0] CH_AT      = 8'd64;
   localparam logic [7:0] CH_PLUS    = 8'd43;
   localparam logic [7:0] CH_NEWLINE = 8'd10;

   localparam logic CSR_KEEP_FRACTION = 1'b0;
   localparam logic CSR_LENGTH_LIMIT  = 1'b1;

   localparam logic [16:0] FRACTION_ONE = 17'd65536;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_value;
      logic [7:0] quality_value;
      logic [2:0] status;
   } result_type;

endpackage

/* sv/fqp_ram.sv */
module fqp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/fastq_record_parser.sv */
// Channel   | Direction | Payload
// req_      | in        | tdata[7:0] data_byte, tuser end_of_input
// rsp_      | out       | tdata[23:0] char_value, quality_value, status; tuser kind
// csr_      | in        | index 0 keep_fraction, 1 length_limit
//
// Most bytes are accepted in CTL_IDLE, then processed in CTL_OUT with a memory access.
// A quality byte within the kept length reads its base, then pairs it in CTL_QREAD.
// A byte that makes a result holds req_tready low until the result is taken.
// Closing a plus line compares the name with the stored tail, stepping CTL_MATCH and
// CTL_MWAIT per name byte; closing a sequence line adds a CTL_KEEP step.
// Reset is synchronous; the memories need no clearing. A stalled rsp_ holds
// the block, and req_tready stays low until the result is taken.
module fastq_record_parser #(
   parameter int MAX_NAME_BYTES = 256,
   parameter int MAX_READ_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] char_value, [15:8] quality_value, [18:16] status
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [16:0] csr_wr_data
);

   localparam int NAW = $clog2(MAX_NAME_BYTES);
   localparam int RAW = $clog2(MAX_READ_BYTES);
   localparam int NLW = NAW + 1;
   localparam int RLW = RAW + 1;

   // configuration
   logic [16:0] keep_fraction_ff;
   logic [10:0] length_limit_ff;

   // parse state
   fqp_pkg::phase_type phase_ff, phase_in;
   fqp_pkg::ctl_type   ctl_ff, ctl_in;
   logic at_start_ff, at_start_in;
   logic failed_ff, failed_in;
   logic over_ff, over_in;
   logic [NLW-1:0] name_len_ff, name_len_in;
   logic [NLW-1:0] plus_len_ff, plus_len_in;
   logic [RLW-1:0] base_cnt_ff, base_cnt_in;
   logic [RLW-1:0] kept_ff, kept_in;
   logic [RLW-1:0] qual_cnt_ff, qual_cnt_in;
   logic [NLW-1:0] idx_ff, idx_in;
   logic match_ok_ff, match_ok_in;
   logic eoi_ff, eoi_in;
   logic [7:0] byte_ff, byte_in;
   logic [RLW+16:0] prod_ff, prod_in;

   fqp_pkg::result_type res_ff, res_in;
   logic res_valid_ff, res_valid_in;

   // memory ports
   logic           nm_we, pt_we, bs_we;
   logic [NAW-1:0] nm_waddr, pt_waddr, nm_raddr, pt_raddr;
   logic [RAW-1:0] bs_waddr, bs_raddr;
   logic [7:0]     nm_rdata, pt_rdata, bs_rdata;

   fqp_ram #(.WIDTH(8), .DEPTH(MAX_NAME_BYTES)) u_name (
      .clock, .wr_en(nm_we), .wr_addr(nm_waddr), .wr_data(byte_ff),
      .rd_addr(nm_raddr), .rd_data(nm_rdata));
   fqp_ram #(.WIDTH(8), .DEPTH(MAX_NAME_BYTES)) u_plus (
      .clock, .wr_en(pt_we), .wr_addr(pt_waddr), .wr_data(byte_ff),
      .rd_addr(pt_raddr), .rd_data(pt_rdata));
   fqp_ram #(.WIDTH(8), .DEPTH(MAX_READ_BYTES)) u_base (
      .clock, .wr_en(bs_we), .wr_addr(bs_waddr), .wr_data(byte_ff),
      .rd_addr(bs_raddr), .rd_data(bs_rdata));

   assign req_tready = (ctl_ff == fqp_pkg::CTL_IDLE) && !res_valid_ff;
   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = {5'd0, res_ff.status, res_ff.quality_value, res_ff.char_value};
   assign rsp_tuser  = res_ff.kind;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_fraction_ff <= fqp_pkg::FRACTION_ONE;
         length_limit_ff  <= 11'd1024;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            fqp_pkg::CSR_KEEP_FRACTION: keep_fraction_ff <= csr_wr_data;
            fqp_pkg::CSR_LENGTH_LIMIT:  length_limit_ff  <= csr_wr_data[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= fqp_pkg::PH_NAME;
         ctl_ff       <= fqp_pkg::CTL_IDLE;
         at_start_ff  <= 1'b1;
         failed_ff    <= 1'b0;
         over_ff      <= 1'b0;
         name_len_ff  <= '0;
         plus_len_ff  <= '0;
         base_cnt_ff  <= '0;
         kept_ff      <= '0;
         qual_cnt_ff  <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         ctl_ff       <= ctl_in;
         at_start_ff  <= at_start_in;
         failed_ff    <= failed_in;
         over_ff      <= over_in;
         name_len_ff  <= name_len_in;
         plus_len_ff  <= plus_len_in;
         base_cnt_ff  <= base_cnt_in;
         kept_ff      <= kept_in;
         qual_cnt_ff  <= qual_cnt_in;
         res_valid_ff <= res_valid_in;
      end
      idx_ff      <= idx_in;
      match_ok_ff <= match_ok_in;
      eoi_ff      <= eoi_in;
      byte_ff     <= byte_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
   end

   logic [NLW:0] plus_total;
   logic [NLW:0] pos_now;
   logic [RLW+16:0] kept_raw;
   logic [RLW-1:0] kept_lim;
   logic close_st_valid;
   logic [2:0] close_st;

   always_comb begin
      phase_in     = phase_ff;
      ctl_in       = ctl_ff;
      at_start_in  = at_start_ff;
      failed_in    = failed_ff;
      over_in      = over_ff;
      name_len_in  = name_len_ff;
      plus_len_in  = plus_len_ff;
      base_cnt_in  = base_cnt_ff;
      kept_in      = kept_ff;
      qual_cnt_in  = qual_cnt_ff;
      idx_in       = idx_ff;
      match_ok_in  = match_ok_ff;
      eoi_in       = eoi_ff;
      byte_in      = byte_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !rsp_tready;
      nm_we = 1'b0; pt_we = 1'b0; bs_we = 1'b0;
      nm_waddr = name_len_ff[NAW-1:0];
      pt_waddr = plus_len_ff[NAW-1:0];
      bs_waddr = base_cnt_ff[RAW-1:0];
      nm_raddr = idx_ff[NAW-1:0];
      plus_total = {1'b0, plus_len_ff} + 1'b1;
      pos_now = plus_total - {1'b0, name_len_ff} + {1'b0, idx_ff};
      pt_raddr = NAW'(pos_now - 1'b1);
      bs_raddr = qual_cnt_ff[RAW-1:0];
      kept_raw = (keep_fraction_ff < fqp_pkg::FRACTION_ONE) ?
                 (prod_ff >> 16) : (RLW+17)'(base_cnt_ff);
      kept_lim = (kept_raw > (RLW+17)'(length_limit_ff)) ?
                 RLW'(length_limit_ff) : RLW'(kept_raw);
      close_st_valid = 1'b0;
      close_st = fqp_pkg::ST_OK;

      unique case (ctl_ff)
         fqp_pkg::CTL_IDLE: begin
            if (req_tvalid && req_tready) begin
               byte_in = req_tdata;
               eoi_in  = req_tuser;
               ctl_in  = fqp_pkg::CTL_OUT;
            end
         end
         // process the latched byte
         fqp_pkg::CTL_OUT: begin
            ctl_in = fqp_pkg::CTL_IDLE;
            if (eoi_ff || byte_ff == fqp_pkg::CH_NEWLINE) begin
               if (eoi_ff && phase_ff == fqp_pkg::PH_NAME && at_start_ff) begin
                  close_st_valid = 1'b1; close_st = fqp_pkg::ST_NONE;
               end else if (eoi_ff && at_start_ff) begin
                  close_st_valid = 1'b1; close_st = fqp_pkg::ST_CUT;
               end else begin
                  unique case (phase_ff)
                     fqp_pkg::PH_NAME: begin
                        if (at_start_ff || failed_ff) begin
                           close_st_valid = 1'b1; close_st = fqp_pkg::ST_NO_AT;
                        end else if (over_ff) begin
                           close_st_valid = 1'b1; close_st = fqp_pkg::ST_OVERLONG;
                        end else begin
                           phase_in = fqp_pkg::PH_SEQ;
                        end
                     end
                     fqp_pkg::PH_SEQ: begin
                        if (at_start_ff) base_cnt_in = '0;
                        if (over_ff) begin
                           close_st_valid = 1'b1; close_st = fqp_pkg::ST_OVERLONG;
                        end else begin
                           prod_in = (RLW+17)'(at_start_ff ? '0 : base_cnt_ff)
                                     * (RLW+17)'(keep_fraction_ff);
                           ctl_in = fqp_pkg::CTL_KEEP;
                        end
                     end
                     fqp_pkg::PH_PLUS: begin
                        if (at_start_ff || failed_ff) begin
                           close_st_valid = 1'b1; close_st = fqp_pkg::ST_PLUS;
                        end else if (over_ff) begin
                           close_st_valid = 1'b1; close_st = fqp_pkg::ST_OVERLONG;
                        end else if (plus_len_ff == '0) begin
                           phase_in = fqp_pkg::PH_QUAL;
                        end else if ({1'b0, name_len_ff} > plus_total) begin
                           close_st_valid = 1'b1; close_st = fqp_pkg::ST_PLUS;
                        end else begin
                           idx_in = '0;
                           match_ok_in = 1'b1;
                           ctl_in = fqp_pkg::CTL_MATCH;
                        end
                     end
                     default: begin
                        close_st_valid = 1'b1;
                        close_st = (failed_ff ||
                                    (at_start_ff ? '0 : qual_cnt_ff) != base_cnt_ff) ?
                                   fqp_pkg::ST_LENGTH : fqp_pkg::ST_OK;
                        if (at_start_ff) qual_cnt_in = '0;
                     end
                  endcase
               end
               if (eoi_ff && !close_st_valid && ctl_in == fqp_pkg::CTL_IDLE) begin
                  close_st_valid = 1'b1; close_st = fqp_pkg::ST_CUT;
               end
               if (eoi_ff && ctl_in != fqp_pkg::CTL_IDLE) begin
                  // plus-match or keep-length still runs; status comes later
               end
               at_start_in = 1'b1;
               failed_in = 1'b0;
               over_in = 1'b0;
               if (close_st_valid || eoi_ff) phase_in = fqp_pkg::PH_NAME;
               if (eoi_ff && ctl_in == fqp_pkg::CTL_KEEP) ctl_in = fqp_pkg::CTL_KEEP;
            end else begin
               at_start_in = 1'b0;
               unique case (phase_ff)
                  fqp_pkg::PH_NAME: begin
                     if (at_start_ff) begin
                        name_len_in = '0;
                        if (byte_ff != fqp_pkg::CH_AT) failed_in = 1'b1;
                     end else if (!failed_ff && !over_ff) begin
                        if (name_len_ff < NLW'(MAX_NAME_BYTES)) begin
                           nm_we = 1'b1;
                           name_len_in = name_len_ff + 1'b1;
                           res_in.kind = fqp_pkg::KIND_NAME;
                           res_in.char_value = byte_ff;
                           res_in.quality_value = '0;
                           res_in.status = fqp_pkg::ST_OK;
                           res_valid_in = 1'b1;
                        end else begin
                           over_in = 1'b1;
                        end
                     end
                  end
                  fqp_pkg::PH_SEQ: begin
                     if (at_start_ff) begin
                        bs_waddr = '0;
                        bs_we = 1'b1;
                        base_cnt_in = RLW'(1);
                     end else if (!over_ff) begin
                        if (base_cnt_ff < RLW'(MAX_READ_BYTES)) begin
                           bs_we = 1'b1;
                           base_cnt_in = base_cnt_ff + 1'b1;
                        end else begin
                           over_in = 1'b1;
                        end
                     end
                  end
                  fqp_pkg::PH_PLUS: begin
                     if (at_start_ff) begin
                        plus_len_in = '0;
                        if (byte_ff != fqp_pkg::CH_PLUS) failed_in = 1'b1;
                     end else if (!failed_ff && !over_ff) begin
                        if (plus_len_ff < NLW'(MAX_NAME_BYTES)) begin
                           pt_we = 1'b1;
                           plus_len_in = plus_len_ff + 1'b1;
                        end else begin
                           over_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                     if (at_start_ff) qual_cnt_in = '0;
                     bs_raddr = at_start_ff ? '0 : qual_cnt_ff[RAW-1:0];
                     if (!failed_ff) begin
                        if ((at_start_ff ? '0 : qual_cnt_ff) < base_cnt_ff) begin
                           if ((at_start_ff ? '0 : qual_cnt_ff) < kept_ff) begin
                              ctl_in = fqp_pkg::CTL_QREAD;
                           end
                           qual_cnt_in = (at_start_ff ? '0 : qual_cnt_ff) + 1'b1;
                        end else begin
                           failed_in = 1'b1;
                        end
                     end
                  end
               endcase
            end
            if (close_st_valid) begin
               res_in.kind = fqp_pkg::KIND_STATUS;
               res_in.char_value = '0;
               res_in.quality_value = '0;
               res_in.status = close_st;
               res_valid_in = 1'b1;
            end
         end
         // base read issued last cycle; pair it with the quality byte
         fqp_pkg::CTL_QREAD: begin
            res_in.kind = fqp_pkg::KIND_PAIR;
            res_in.char_value = bs_rdata;
            res_in.quality_value = byte_ff;
            res_in.status = fqp_pkg::ST_OK;
            res_valid_in = 1'b1;
            ctl_in = fqp_pkg::CTL_IDLE;
         end
         // keep length from the registered product
         fqp_pkg::CTL_KEEP: begin
            kept_in = kept_lim;
            ctl_in = fqp_pkg::CTL_IDLE;
            if (eoi_ff) begin
               res_in.kind = fqp_pkg::KIND_STATUS;
               res_in.char_value = '0;
               res_in.quality_value = '0;
               res_in.status = fqp_pkg::ST_CUT;
               res_valid_in = 1'b1;
               phase_in = fqp_pkg::PH_NAME;
            end else begin
               phase_in = fqp_pkg::PH_PLUS;
            end
         end
         // issue reads for the name-tail compare
         fqp_pkg::CTL_MATCH: begin
            if (idx_ff == name_len_ff) begin
               ctl_in = fqp_pkg::CTL_MWAIT;
            end else begin
               ctl_in = fqp_pkg::CTL_MWAIT;
            end
         end
         // compare one byte, then read the next pair
         default: begin
            if (idx_ff == name_len_ff) begin
               ctl_in = fqp_pkg::CTL_IDLE;
               if (match_ok_ff && !eoi_ff) begin
                  phase_in = fqp_pkg::PH_QUAL;
               end else begin
                  phase_in = fqp_pkg::PH_NAME;
                  res_in.kind = fqp_pkg::KIND_STATUS;
                  res_in.char_value = '0;
                  res_in.quality_value = '0;
                  res_in.status = match_ok_ff ? fqp_pkg::ST_CUT : fqp_pkg::ST_PLUS;
                  res_valid_in = 1'b1;
               end
            end else begin
               if (((pos_now == '0) ? fqp_pkg::CH_PLUS : pt_rdata) != nm_rdata) begin
                  match_ok_in = 1'b0;
               end
               idx_in = idx_ff + 1'b1;
               ctl_in = fqp_pkg::CTL_MATCH;
            end
         end
      endcase
   end

   // a result is only built while the previous one has left
   assert property (@(posedge clock) disable iff (reset)
      (ctl_ff != fqp_pkg::CTL_IDLE) |-> !res_valid_ff)
      else $error("result pending while work in progress");

   // an accepted request always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (ctl_ff == fqp_pkg::CTL_OUT))
      else $error("accepted request not processed");

   // a quality pair never goes past the kept count
   assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == fqp_pkg::CTL_QREAD) |-> (qual_cnt_ff <= kept_ff))
      else $error("pair emitted past kept length");

endmodule

/* tb/fastq_record_parser_test.sv */
module fastq_record_parser_test;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tuser;   // [0] end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [7:0] char_value, [15:8] quality_value, [18:16] status
   logic [1:0]  rsp_tuser;   // [1:0] kind
   logic        csr_wr_en;
   logic        csr_index;
   logic [16:0] csr_wr_data;

   localparam int NAME_CAP     = 256;
   localparam int READ_CAP     = 1024;
   localparam int SETTLE_WAIT  = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int WATCH_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 200;

   fastq_record_parser dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // parser shadow state
   fqp_pkg::phase_type shadow_phase;
   bit          line_open_start;
   bit          line_bad;
   bit          line_long;
   logic [7:0]  name_mem [NAME_CAP];
   logic [7:0]  tail_mem [NAME_CAP];
   logic [7:0]  base_mem [READ_CAP];
   int          name_len;
   int          tail_len;
   int          base_cnt;
   int          kept_cnt;
   int          qual_cnt;
   logic [16:0] keep_frac;
   logic [10:0] base_limit;

   fqp_pkg::result_type expected_results [$];
   int          error_count;
   int          sent_items;
   bit          hold_request;
   int          idle_cycles;

   function automatic void push_result(logic [1:0] k, logic [7:0] c, logic [7:0] q,
                                       logic [2:0] s);
      fqp_pkg::result_type r;
      r.kind = k;
      r.char_value = c;
      r.quality_value = q;
      r.status = s;
      expected_results.push_back(r);
   endfunction

   // does the plus tail end with the stored name
   function automatic bit tail_has_name();
      int total;
      int pos;
      logic [7:0] c;
      total = tail_len + 1;
      if (tail_len == 0) return 1'b1;
      if (name_len > total) return 1'b0;
      for (int i = 0; i < name_len; i++) begin
         pos = total - name_len + i;
         c = (pos == 0) ? fqp_pkg::CH_PLUS : tail_mem[pos - 1];
         if (c != name_mem[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   // close the open line; -1 means the record goes on
   function automatic int close_line();
      int st;
      bit empty;
      longint k;
      st = -1;
      empty = line_open_start;
      case (shadow_phase)
         fqp_pkg::PH_NAME: begin
            if (empty || line_bad) st = int'(fqp_pkg::ST_NO_AT);
            else if (line_long) st = int'(fqp_pkg::ST_OVERLONG);
            else shadow_phase = fqp_pkg::PH_SEQ;
         end
         fqp_pkg::PH_SEQ: begin
            if (empty) base_cnt = 0;
            if (line_long) st = int'(fqp_pkg::ST_OVERLONG);
            else begin
               k = base_cnt;
               if (keep_frac < fqp_pkg::FRACTION_ONE)
                  k = (longint'(base_cnt) * longint'(keep_frac)) >> 16;
               if (k > longint'(base_limit)) k = longint'(base_limit);
               kept_cnt = int'(k);
               shadow_phase = fqp_pkg::PH_PLUS;
            end
         end
         fqp_pkg::PH_PLUS: begin
            if (empty || line_bad) st = int'(fqp_pkg::ST_PLUS);
            else if (line_long) st = int'(fqp_pkg::ST_OVERLONG);
            else if (tail_has_name()) shadow_phase = fqp_pkg::PH_QUAL;
            else st = int'(fqp_pkg::ST_PLUS);
         end
         default: begin
            if (empty) qual_cnt = 0;
            st = (line_bad || qual_cnt != base_cnt) ? int'(fqp_pkg::ST_LENGTH)
                                                    : int'(fqp_pkg::ST_OK);
         end
      endcase
      if (st >= 0) shadow_phase = fqp_pkg::PH_NAME;
      line_open_start = 1'b1;
      line_bad = 1'b0;
      line_long = 1'b0;
      return st;
   endfunction

   // work out what one accepted request yields
   function automatic void parse_byte(logic [7:0] b, logic eoi);
      int st;
      if (eoi) begin
         if (shadow_phase == fqp_pkg::PH_NAME && line_open_start)
            st = int'(fqp_pkg::ST_NONE);
         else if (!line_open_start) begin
            st = close_line();
            if (st < 0) st = int'(fqp_pkg::ST_CUT);
         end else st = int'(fqp_pkg::ST_CUT);
         shadow_phase = fqp_pkg::PH_NAME;
         line_open_start = 1'b1;
         line_bad = 1'b0;
         line_long = 1'b0;
         push_result(fqp_pkg::KIND_STATUS, 8'd0, 8'd0, st[2:0]);
         return;
      end
      if (b == fqp_pkg::CH_NEWLINE) begin
         st = close_line();
         if (st >= 0) push_result(fqp_pkg::KIND_STATUS, 8'd0, 8'd0, st[2:0]);
         return;
      end
      case (shadow_phase)
         fqp_pkg::PH_NAME: begin
            if (line_open_start) begin
               name_len = 0;
               if (b != fqp_pkg::CH_AT) line_bad = 1'b1;
            end else if (!line_bad && !line_long) begin
               if (name_len < NAME_CAP) begin
                  name_mem[name_len] = b;
                  name_len++;
                  push_result(fqp_pkg::KIND_NAME, b, 8'd0, fqp_pkg::ST_OK);
               end else line_long = 1'b1;
            end
         end
         fqp_pkg::PH_SEQ: begin
            if (line_open_start) base_cnt = 0;
            if (!line_long) begin
               if (base_cnt < READ_CAP) begin
                  base_mem[base_cnt] = b;
                  base_cnt++;
               end else line_long = 1'b1;
            end
         end
         fqp_pkg::PH_PLUS: begin
            if (line_open_start) begin
               tail_len = 0;
               if (b != fqp_pkg::CH_PLUS) line_bad = 1'b1;
            end else if (!line_bad && !line_long) begin
               if (tail_len < NAME_CAP) begin
                  tail_mem[tail_len] = b;
                  tail_len++;
               end else line_long = 1'b1;
            end
         end
         default: begin
            if (line_open_start) qual_cnt = 0;
            if (!line_bad) begin
               if (qual_cnt < base_cnt) begin
                  if (qual_cnt < kept_cnt)
                     push_result(fqp_pkg::KIND_PAIR, base_mem[qual_cnt], b, fqp_pkg::ST_OK);
                  qual_cnt++;
               end else line_bad = 1'b1;
            end
         end
      endcase
      line_open_start = 1'b0;
   endfunction

   // offer one request after a random gap and wait for it to be taken
   task automatic send_item(logic [7:0] b, logic eoi);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = b;
      req_tuser = eoi;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      parse_byte(b, eoi);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic send_line(byte unsigned text [$]);
      foreach (text[i]) send_item(text[i], 1'b0);
      send_item(fqp_pkg::CH_NEWLINE, 1'b0);
   endtask

   function automatic byte unsigned any_text_byte();
      byte unsigned b;
      do b = 8'($urandom_range(0, 255)); while (b == fqp_pkg::CH_NEWLINE);
      return b;
   endfunction

   function automatic byte unsigned base_byte();
      byte unsigned letters [5] = '{"A", "C", "G", "T", "N"};
      if ($urandom_range(0, 9) == 0) return any_text_byte();
      return letters[$urandom_range(0, 4)];
   endfunction

   // wait until the block is idle
   task automatic settle();
      req_tvalid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [16:0] value);
      csr_index = idx;
      csr_wr_data = value;
      csr_wr_en = 1'b1;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == fqp_pkg::CSR_KEEP_FRACTION) keep_frac = value;
      else base_limit = value[10:0];
   endtask

   // one record, mostly well formed, sometimes broken on purpose
   task automatic send_record(int max_seq);
      byte unsigned name_line [$];
      byte unsigned seq_line [$];
      byte unsigned plus_line [$];
      byte unsigned qual_line [$];
      int mode;
      int slen;
      int qlen;
      mode = $urandom_range(0, 19);
      name_line.push_back((mode == 0) ? any_text_byte() : fqp_pkg::CH_AT);
      repeat ($urandom_range(0, 10)) name_line.push_back(any_text_byte());
      slen = $urandom_range(0, max_seq);
      repeat (slen) seq_line.push_back(base_byte());
      plus_line.push_back((mode == 1) ? any_text_byte() : fqp_pkg::CH_PLUS);
      if (mode == 5) repeat ($urandom_range(1, 4)) plus_line.push_back(any_text_byte());
      if (mode == 5 || $urandom_range(0, 1) == 1)
         for (int i = 1; i < name_line.size(); i++) plus_line.push_back(name_line[i]);
      if (mode == 6) plus_line.push_back(any_text_byte());
      qlen = slen;
      if (mode == 2 && qlen > 0) qlen = $urandom_range(0, qlen - 1);
      if (mode == 3) qlen = slen + $urandom_range(1, 3);
      repeat (qlen) qual_line.push_back(8'($urandom_range(33, 126)));
      if (mode == 4) begin
         // cut the record inside some line
         case ($urandom_range(0, 3))
            0: foreach (name_line[i]) send_item(name_line[i], 1'b0);
            1: begin
               send_line(name_line);
               foreach (seq_line[i]) send_item(seq_line[i], 1'b0);
            end
            2: begin
               send_line(name_line);
               send_line(seq_line);
            end
            default: begin
               send_line(name_line);
               send_line(seq_line);
               send_line(plus_line);
               foreach (qual_line[i]) send_item(qual_line[i], 1'b0);
            end
         endcase
         send_item(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         send_line(name_line);
         send_line(seq_line);
         send_line(plus_line);
         send_line(qual_line);
      end
   endtask

   task automatic test_directed();
      byte unsigned t [$];
      send_item(8'hFF, 1'b1);                         // end with no record
      send_line('{"@", "r"}); send_line('{"A", 8'h0D}); send_line('{"+", "r"});
      send_line('{8'h00, 8'hFF});                     // clean record, CR as data
      send_line('{"x", "y"});                         // name without @
      send_line(t);                                   // empty name line
      send_line('{"@", 8'hA5}); send_line('{"C"}); send_line('{"-"}); // bad plus
      send_line('{"@", "q"}); send_line('{"G", "T"}); send_line('{"+"});
      send_line('{"!"});                              // short quality
      send_item(8'h00, 1'b1);
   endtask

   task automatic test_capacity();
      byte unsigned nm [$];
      byte unsigned pl [$];
      // name past capacity
      nm.push_back(fqp_pkg::CH_AT);
      repeat (NAME_CAP + 4) nm.push_back(any_text_byte());
      send_line(nm);
      // plus tail past capacity, ending with the name
      nm = '{"@", "L"};
      pl.push_back(fqp_pkg::CH_PLUS);
      repeat (NAME_CAP + 2) pl.push_back("x");
      pl.push_back("L");
      send_line(nm); send_line('{"A"}); send_line(pl);
   endtask

   task automatic test_keep_settings();
      logic [16:0] fracs [4] = '{17'd0, 17'd65535, 17'd32768, fqp_pkg::FRACTION_ONE};
      logic [10:0] limits [4] = '{11'd0, 11'd1024, 11'd3, 11'd17};
      for (int i = 0; i < 4; i++) begin
         settle();
         write_csr(fqp_pkg::CSR_KEEP_FRACTION, fracs[i]);
         write_csr(fqp_pkg::CSR_LENGTH_LIMIT, {6'd0, limits[i]});
         repeat (2) send_record(16);
      end
   endtask

   // receiver holds off while a long name keeps the block busy
   task automatic test_backpressure();
      byte unsigned nm [$];
      settle();
      nm.push_back(fqp_pkg::CH_AT);
      repeat (60) nm.push_back(any_text_byte());
      hold_request = 1'b1;
      send_line(nm);
      send_line('{"A"}); send_line('{"+"}); send_line('{"I"});
   endtask

   task automatic test_random();
      int phase_items;
      for (int p = 0; p < 4; p++) begin
         settle();
         write_csr(fqp_pkg::CSR_KEEP_FRACTION,
                   ($urandom_range(0, 2) == 0) ? fqp_pkg::FRACTION_ONE
                                               : 17'($urandom_range(0, 65535)));
         write_csr(fqp_pkg::CSR_LENGTH_LIMIT, 17'($urandom_range(0, 40)));
         phase_items = sent_items + RANDOM_ITEMS / 4;
         while (sent_items < phase_items) begin
            case ($urandom_range(0, 9))
               0: repeat ($urandom_range(1, 8)) begin
                  // noise, newlines and markers included
                  case ($urandom_range(0, 3))
                     0: send_item(fqp_pkg::CH_NEWLINE, 1'b0);
                     1: send_item(fqp_pkg::CH_AT, 1'b0);
                     2: send_item(fqp_pkg::CH_PLUS, 1'b0);
                     default: send_item(8'($urandom_range(0, 255)), 1'b0);
                  endcase
               end
               1: send_item(8'($urandom_range(0, 255)), 1'b1);
               default: send_record(12);
            endcase
         end
      end
   endtask

   // result side: random stalls, quiet stretches and one long hold-off
   initial begin : result_side
      fqp_pkg::result_type got;
      fqp_pkg::result_type want;
      int stall;
      int quiet;
      quiet = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         if (quiet > 0) quiet--;
         else if ($urandom_range(0, 19) == 0) quiet = $urandom_range(20, 60);
         stall = (quiet > 0) ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.kind = rsp_tuser;
         got.char_value = rsp_tdata[7:0];
         got.quality_value = rsp_tdata[15:8];
         got.status = rsp_tdata[18:16];
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result kind %0d char %0h qual %0h status %0d",
                     $time, got.kind, got.char_value, got.quality_value, got.status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.kind != want.kind) begin
               $display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
               error_count++;
            end
            if (got.char_value != want.char_value) begin
               $display("%0t: char_value expected %0h got %0h", $time,
                        want.char_value, got.char_value);
               error_count++;
            end
            if (got.quality_value != want.quality_value) begin
               $display("%0t: quality_value expected %0h got %0h", $time,
                        want.quality_value, got.quality_value);
               error_count++;
            end
            if (got.status != want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
               error_count++;
            end
         end
         @(negedge clock);
      end
   end

   // count cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else if (idle_cycles >= WATCH_LIMIT) begin
         $display("FAIL");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = fqp_pkg::CSR_KEEP_FRACTION;
      csr_wr_data = 17'd0;
      hold_request = 1'b0;
      error_count = 0;
      sent_items = 0;
      idle_cycles = 0;
      shadow_phase = fqp_pkg::PH_NAME;
      line_open_start = 1'b1;
      line_bad = 1'b0;
      line_long = 1'b0;
      name_len = 0;
      tail_len = 0;
      base_cnt = 0;
      kept_cnt = 0;
      qual_cnt = 0;
      keep_frac = fqp_pkg::FRACTION_ONE;
      base_limit = 11'd1024;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_capacity();
      test_keep_settings();
      test_backpressure();
      test_random();
      settle();
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

/* fastq_record_parser.f */
sv/fqp_pkg.sv
sv/fqp_ram.sv
sv/fastq_record_parser.sv
tb/fastq_record_parser_test.sv
